>>> rtl/core/biou_pkg.sv
// Shared types for the box intersection-over-union pipeline.
`default_nettype none

package biou_pkg;

  // Control word that travels with each beat down the pipeline.
  typedef struct packed {
    logic valid;  // stage holds a live beat
    logic found;  // intersection valid and union positive
    logic full;   // intersection equals union, ratio is exactly one
  } biou_ctl_t;

  localparam biou_ctl_t BIOU_CTL_IDLE = '{valid: 1'b0, found: 1'b0, full: 1'b0};

endpackage

`default_nettype wire

>>> rtl/core/biou_front.sv
// Front stages: box checks and edge differences, area products, union and full-overlap test.
`default_nettype none

module biou_front
  import biou_pkg::*;
#(
  parameter int C = 16,
  parameter int W = 2 * C + 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [8*C-1:0]   coords,
  output biou_ctl_t             ctl_o,
  output logic      [W-1:0]     uni_o,
  output logic      [W-1:0]     rem_o
);

  localparam int AW = 2 * C;

  logic signed [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic signed [C-1:0] ix0, iy0, ix1, iy1;
  logic                a_ok, i_ok;

  biou_ctl_t  ctl1_r, ctl1_nxt, ctl2_r, ctl3_r, ctl3_nxt;
  logic [C-1:0]  dax_r, day_r, dbx_r, dby_r, dix_r, diy_r;
  logic [AW-1:0] area_a_r, area_b_r, area_i_r;
  logic [AW-1:0] area_a_nxt, area_b_nxt, area_i_nxt;
  logic [AW:0]   uni_nxt;
  logic [W-1:0]  uni_r, rem_r;

  assign ax0 = coords[0*C +: C];
  assign ay0 = coords[1*C +: C];
  assign ax1 = coords[2*C +: C];
  assign ay1 = coords[3*C +: C];
  assign bx0 = coords[4*C +: C];
  assign by0 = coords[5*C +: C];
  assign bx1 = coords[6*C +: C];
  assign by1 = coords[7*C +: C];

  assign ix0 = (ax0 > bx0) ? ax0 : bx0;
  assign iy0 = (ay0 > by0) ? ay0 : by0;
  assign ix1 = (ax1 < bx1) ? ax1 : bx1;
  assign iy1 = (ay1 < by1) ? ay1 : by1;

  assign a_ok = (ax0 < ax1) && (ay0 < ay1);
  assign i_ok = (ix0 < ix1) && (iy0 < iy1);

  always_comb begin
    ctl1_nxt       = BIOU_CTL_IDLE;
    ctl1_nxt.valid = in_valid;
    ctl1_nxt.found = a_ok && i_ok;
  end

  // Differences are taken modulo 2^C; they are exact whenever the beat is found.
  always_ff @(posedge clk) begin
    if (en) begin
      dax_r <= C'(ax1 - ax0);
      day_r <= C'(ay1 - ay0);
      dbx_r <= C'(bx1 - bx0);
      dby_r <= C'(by1 - by0);
      dix_r <= C'(ix1 - ix0);
      diy_r <= C'(iy1 - iy0);
    end
  end

  assign area_a_nxt = dax_r * day_r;
  assign area_b_nxt = dbx_r * dby_r;
  assign area_i_nxt = dix_r * diy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      area_a_r <= area_a_nxt;
      area_b_r <= area_b_nxt;
      area_i_r <= area_i_nxt;
    end
  end

  assign uni_nxt = {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, area_i_r};

  always_comb begin
    ctl3_nxt       = ctl2_r;
    ctl3_nxt.found = ctl2_r.found && (uni_nxt != '0);
    ctl3_nxt.full  = {1'b0, area_i_r} >= uni_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uni_r <= W'(uni_nxt);
      rem_r <= W'(area_i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= BIOU_CTL_IDLE;
      ctl2_r <= BIOU_CTL_IDLE;
      ctl3_r <= BIOU_CTL_IDLE;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl3_nxt;
    end
  end

  assign ctl_o = ctl3_r;
  assign uni_o = uni_r;
  assign rem_o = rem_r;

endmodule

`default_nettype wire

>>> rtl/core/biou_cell.sv
// One restoring-division cell: develops one quotient bit and hands the partial remainder on.
`default_nettype none

module biou_cell
  import biou_pkg::*;
#(
  parameter int W  = 34,
  parameter int QW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire biou_ctl_t     ctl_i,
  input  wire logic [W-1:0]  uni_i,
  input  wire logic [W-1:0]  rem_i,
  input  wire logic [QW-1:0] quo_i,
  output biou_ctl_t          ctl_o,
  output logic      [W-1:0]  uni_o,
  output logic      [W-1:0]  rem_o,
  output logic      [QW-1:0] quo_o
);

  biou_ctl_t     ctl_r;
  logic [W-1:0]  uni_r, rem_r, rem_shl, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic          take;

  // The incoming remainder is below the union, so the doubled value still fits.
  assign rem_shl = {rem_i[W-2:0], 1'b0};
  assign take    = rem_shl >= uni_i;
  assign rem_nxt = take ? (rem_shl - uni_i) : rem_shl;
  assign quo_nxt = {quo_i[QW-2:0], take};

  always_ff @(posedge clk) begin
    if (en) begin
      uni_r <= uni_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= BIOU_CTL_IDLE;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  assign ctl_o = ctl_r;
  assign uni_o = uni_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire

>>> rtl/core/box_iou_unit.sv
// Top level of the axis-aligned box intersection-over-union unit.
// Throughput: one box pair per cycle; the whole pipeline advances together.
// A stalled output holds every stage, and new beats are taken whenever the output
// register is empty or is being drained in the same cycle.
// Reset (rst_n low, synchronous) empties every stage; data registers keep their contents.
`default_nettype none

module box_iou_unit
  import biou_pkg::*;
#(
  parameter int COORD_BITS      = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel: one box pair per beat.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // in_tdata, lowest bit up: box_a_x_min, box_a_y_min, box_a_x_max, box_a_y_max,
  // box_b_x_min, box_b_y_min, box_b_x_max, box_b_y_max, each COORD_BITS signed.
  input  wire logic [8*COORD_BITS-1:0]        in_tdata,
  // Result channel: one beat per box pair.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // out_tdata, lowest bit up: overlap_ratio (RATIO_FRAC_BITS+1 bits), zero fill to bytes.
  output logic [((RATIO_FRAC_BITS+8)/8)*8-1:0] out_tdata,
  // out_tuser: overlap_found.
  output logic                                out_tuser
);

  localparam int C   = COORD_BITS;
  localparam int F   = RATIO_FRAC_BITS;
  localparam int W   = 2 * C + 2;
  localparam int OW  = ((F + 8) / 8) * 8;
  localparam logic [F:0] RATIO_ONE = {1'b1, {F{1'b0}}};

  // Global advance: every stage moves when the output register can take a beat.
  logic en;

  biou_ctl_t     ctl   [F+1];
  logic [W-1:0]  uni   [F+1];
  logic [W-1:0]  rem   [F+1];
  logic [F-1:0]  quo   [F+1];

  logic          out_valid_r;
  logic          out_found_r, out_found_nxt;
  logic [F:0]    out_ratio_r, out_ratio_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  biou_front #(
    .C (C),
    .W (W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .coords   (in_tdata),
    .ctl_o    (ctl[0]),
    .uni_o    (uni[0]),
    .rem_o    (rem[0])
  );

  assign quo[0] = '0;

  // Division row: each cell adds one fraction bit of intersection / union.
  for (genvar k = 0; k < F; k++) begin : g_cell
    biou_cell #(
      .W  (W),
      .QW (F)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl[k]),
      .uni_i (uni[k]),
      .rem_i (rem[k]),
      .quo_i (quo[k]),
      .ctl_o (ctl[k+1]),
      .uni_o (uni[k+1]),
      .rem_o (rem[k+1]),
      .quo_o (quo[k+1])
    );
  end

  // Final selection: no overlap gives zero, a full overlap gives exactly one.
  always_comb begin
    out_found_nxt = ctl[F].found;
    priority if (!ctl[F].found) begin
      out_ratio_nxt = '0;
    end else if (ctl[F].full) begin
      out_ratio_nxt = RATIO_ONE;
    end else begin
      out_ratio_nxt = {1'b0, quo[F]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ratio_r <= out_ratio_nxt;
      out_found_r <= out_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl[F].valid;
    end
  end

  // The uni and rem of the last cell are not needed past the division row.
  logic unused_tail;
  assign unused_tail = ^{uni[F], rem[F]};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'(out_ratio_r);
  assign out_tuser  = out_found_r;

endmodule

`default_nettype wire

>>> rtl/core/biou_chk.sv
// Port-level checker for the box intersection-over-union unit, bound to the top level.
`default_nettype none

module biou_chk #(
  parameter int COORD_BITS      = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input wire logic                                    clk,
  input wire logic                                    rst_n,
  input wire logic                                    in_tvalid,
  input wire logic                                    in_tready,
  input wire logic [8*COORD_BITS-1:0]                 in_tdata,
  input wire logic                                    out_tvalid,
  input wire logic                                    out_tready,
  input wire logic [((RATIO_FRAC_BITS+8)/8)*8-1:0]    out_tdata,
  input wire logic                                    out_tuser
);

  localparam int F = RATIO_FRAC_BITS;

  logic unused_in;
  assign unused_in = ^{in_tvalid, in_tdata};

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // No overlap always reports a zero ratio.
  a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero ratio without overlap");

  // The ratio never exceeds one.
  a_ratio_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[F] |-> out_tdata[F-1:0] == '0)
    else $error("ratio above one");

  // The unit takes input whenever its output side is free.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with output free");

endmodule

bind box_iou_unit biou_chk #(
  .COORD_BITS      (COORD_BITS),
  .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
) u_biou_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
